>>> rtl/tmrle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tilemap RLE word decoder.
// No dependencies; used by tmrle_ctrl, tmrle_datapath and the top level.
package tmrle_pkg;

	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 24;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [ADDR_W-1:0] BASE_RESET  = 24'h10F030;
	localparam logic [ADDR_W-1:0] FIX_ADDRESS = 24'h10F730;
	localparam logic [WORD_W-1:0] FIX_VALUE   = 16'h0C80;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIX_ENABLE   = 2'd1;

	typedef struct packed {
		logic emit_tile;   // load a tile write into the output register
		logic sel_held;    // tile value from held run value, else input word
		logic tile_final;  // this tile is the last one of its item
		logic emit_fix;    // load the corrective write
		logic ld_held;     // capture run value
		logic ld_count;    // capture run count
	} cmd_t;

	typedef struct packed {
		logic word_zero;   // input word is an escape
		logic run_last;    // one copy left in the run
		logic fix_due;     // a final tile now would end the picture with a fix write
	} status_t;

endpackage

>>> rtl/tmrle_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, row/column/address tracking, run counter
// and the output beat register. Depends on tmrle_pkg.
module tmrle_datapath #(
	parameter int ROWS       = 28,
	parameter int COLUMNS    = 40,
	parameter int ROW_STRIDE = 128,
	parameter int MAX_RUN    = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tmrle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmrle_pkg::ADDR_W-1:0]      cfg_data,
	input  logic [tmrle_pkg::WORD_W-1:0]      word,
	input  tmrle_pkg::cmd_t                   cmd,
	output tmrle_pkg::status_t                status,
	output logic [tmrle_pkg::ADDR_W-1:0]      tile_address,
	output logic [tmrle_pkg::WORD_W-1:0]      tile_value,
	output logic                              last,
	output logic                              picture_done,
	output logic                              overrun
);

	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int AW = tmrle_pkg::ADDR_W;

	logic [AW-1:0]                     base_q;
	logic                              fix_en_q;
	logic [tmrle_pkg::WORD_W-1:0]      held_q;
	logic [tmrle_pkg::COL_W-1:0]       column_q;
	logic [tmrle_pkg::ROW_W-1:0]       row_q;
	logic [AW-1:0]                     addr_q;
	logic [RUN_W-1:0]                  rem_q;
	logic                              over_q;

	logic [tmrle_pkg::COL_W-1:0]       col_next;
	logic [tmrle_pkg::ROW_W-1:0]       row_inc;
	logic                              row_end;
	logic                              pic_end;
	logic                              over_w;
	logic [RUN_W-1:0]                  copies;
	logic [AW-1:0]                     row_start;
	logic                              end_row;

	assign col_next  = column_q + tmrle_pkg::COL_W'(1);
	assign row_inc   = row_q + tmrle_pkg::ROW_W'(1);
	assign row_end   = col_next >= tmrle_pkg::COL_W'(COLUMNS);
	assign pic_end   = row_inc >= tmrle_pkg::ROW_W'(ROWS);
	assign row_start = base_q + AW'(row_inc) * AW'(ROW_STRIDE);
	assign end_row   = cmd.tile_final && row_end;

	// run length clipped to MAX_RUN copies
	assign over_w = word >= tmrle_pkg::WORD_W'(MAX_RUN);
	assign copies = over_w ? RUN_W'(MAX_RUN) : RUN_W'(word) + RUN_W'(1);

	assign status.word_zero = word == '0;
	assign status.run_last  = rem_q == RUN_W'(1);
	assign status.fix_due   = row_end && pic_end && fix_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= tmrle_pkg::BASE_RESET;
			fix_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tmrle_pkg::REG_BASE_ADDRESS: base_q   <= cfg_data;
				tmrle_pkg::REG_FIX_ENABLE:   fix_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			column_q <= '0;
			row_q    <= '0;
			addr_q   <= tmrle_pkg::BASE_RESET;
			rem_q    <= '0;
			over_q   <= 1'b0;
		end else begin
			if (cmd.ld_held) begin
				held_q <= word;
			end
			if (cmd.ld_count) begin
				rem_q  <= copies;
				over_q <= over_w;
			end
			if (cmd.emit_tile) begin
				if (cmd.sel_held) begin
					rem_q <= rem_q - RUN_W'(1);
				end else begin
					over_q <= 1'b0;
				end
				if (end_row) begin
					column_q <= '0;
					if (pic_end) begin
						row_q  <= '0;
						addr_q <= base_q;
					end else begin
						row_q  <= row_inc;
						addr_q <= row_start;
					end
				end else begin
					column_q <= col_next;
					addr_q   <= addr_q + AW'(2);
				end
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (cmd.emit_tile) begin
			tile_address <= addr_q;
			tile_value   <= cmd.sel_held ? held_q : word;
			last         <= cmd.tile_final && !(end_row && pic_end && fix_en_q);
			picture_done <= end_row && pic_end && !fix_en_q;
			overrun      <= cmd.tile_final && cmd.sel_held && over_q
			                && !(end_row && pic_end && fix_en_q);
		end else if (cmd.emit_fix) begin
			tile_address <= tmrle_pkg::FIX_ADDRESS;
			tile_value   <= tmrle_pkg::FIX_VALUE;
			last         <= 1'b1;
			picture_done <= 1'b1;
			overrun      <= over_q;
		end
	end

endmodule

>>> rtl/tmrle_ctrl.sv
`timescale 1ns / 1ps
// Controller: word phase / run / fix-write sequencer and output valid.
// Depends on tmrle_pkg.
module tmrle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tmrle_pkg::status_t status,
	output tmrle_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_TILE  = 3'd0;
	localparam logic [2:0] S_VALUE = 3'd1;
	localparam logic [2:0] S_COUNT = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_FIX   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;
	logic       accept;
	logic       emit;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !slot_free
	                   || !(state_q == S_TILE || state_q == S_VALUE || state_q == S_COUNT);
	assign accept    = in_valid && !in_stall;
	assign emit      = cmd.emit_tile || cmd.emit_fix;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_TILE: begin
				if (accept) begin
					if (status.word_zero) begin
						state_d = S_VALUE;
					end else begin
						cmd.emit_tile  = 1'b1;
						cmd.tile_final = 1'b1;
						state_d = status.fix_due ? S_FIX : S_TILE;
					end
				end
			end
			S_VALUE: begin
				if (accept) begin
					cmd.ld_held = 1'b1;
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				if (accept) begin
					cmd.ld_count = 1'b1;
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (slot_free) begin
					cmd.emit_tile  = 1'b1;
					cmd.sel_held   = 1'b1;
					cmd.tile_final = status.run_last;
					if (status.run_last) begin
						state_d = status.fix_due ? S_FIX : S_TILE;
					end
				end
			end
			S_FIX: begin
				if (slot_free) begin
					cmd.emit_fix = 1'b1;
					state_d = S_TILE;
				end
			end
			default: state_d = S_TILE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TILE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/tilemap_rle_word_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the tilemap RLE word decoder: controller plus datapath.
// Depends on tmrle_pkg, tmrle_ctrl and tmrle_datapath.
//
// Input channel (in_valid/in_stall, word) takes one 16-bit compressed word
// per beat. A non-zero word is one tile; a zero word escapes, the next word
// is the run value and the one after it the count (count+1 copies, clipped
// to MAX_RUN with overrun set). Output channel (out_valid/out_stall) moves
// one tile RAM write per beat from a single output register; last marks the
// final write of an input word, picture_done and overrun ride on that beat.
// Timing: a literal tile appears in the cycle after its word is taken; a run's
// first copy is emitted from the run state entered on its count word, then
// registered. The input takes literal, escape, value and count words back to
// back, stalls during a run and the corrective write (after the last row when
// fix_enable is set); the run counter emits one write a cycle. While out_stall
// holds a beat, the sequencer halts and in_stall rises; nothing is dropped.
// Config port (cfg_valid/cfg_ready, always ready): index 0 base_address,
// index 1 fix_enable; write only while idle. A new base takes effect at the
// next row start. Reset: base 0x10F030, fix off, first row, first column.
module tilemap_rle_word_decoder_unit #(
	parameter int ROWS       = 28,
	parameter int COLUMNS    = 40,
	parameter int ROW_STRIDE = 128,
	parameter int MAX_RUN    = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmrle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmrle_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tmrle_pkg::WORD_W-1:0]      word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tmrle_pkg::ADDR_W-1:0]      tile_address,
	output logic [tmrle_pkg::WORD_W-1:0]      tile_value,
	output logic                              last,
	output logic                              picture_done,
	output logic                              overrun
);

	tmrle_pkg::cmd_t    cmd;
	tmrle_pkg::status_t status;

	assign cfg_ready = 1'b1;

	tmrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tmrle_datapath #(
		.ROWS       (ROWS),
		.COLUMNS    (COLUMNS),
		.ROW_STRIDE (ROW_STRIDE),
		.MAX_RUN    (MAX_RUN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.word         (word),
		.cmd          (cmd),
		.status       (status),
		.tile_address (tile_address),
		.tile_value   (tile_value),
		.last         (last),
		.picture_done (picture_done),
		.overrun      (overrun)
	);

	// flags only ever ride on the closing beat of an item
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && picture_done |-> last)
		else $error("picture_done without last");

	a_over_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> last)
		else $error("overrun without last");

	// a run still in progress holds off the input side
	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_tile && !cmd.tile_final |=> in_stall)
		else $error("input taken in the middle of a run");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_tile || cmd.emit_fix |=> out_valid)
		else $error("emitted beat not presented");

endmodule

>>> test/tb_tilemap_rle_word_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for tilemap_rle_word_decoder_unit: directed table then random
// escape/run streams under several idle mixes, checked beat by beat against a predictor.
// Depends on tmrle_pkg and the RTL of the decoder.
module tb_tilemap_rle_word_decoder_unit;

	localparam int ROWS          = 28;
	localparam int COLUMNS       = 40;
	localparam int ROW_STRIDE    = 128;
	localparam int MAX_RUN       = 63;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTS    = 50;

	typedef enum logic [1:0] {
		EXPECT_TILE  = 2'd0,
		EXPECT_VALUE = 2'd1,
		EXPECT_COUNT = 2'd2
	} dec_phase_t;

	typedef struct packed {
		logic [tmrle_pkg::ADDR_W-1:0] addr;
		logic [tmrle_pkg::WORD_W-1:0] val;
		logic                         last;
		logic                         done;
		logic                         over;
	} tile_wr_t;

	typedef struct packed {
		logic [tmrle_pkg::WORD_W-1:0] w;
		logic                         typed;
		logic [tmrle_pkg::ADDR_W-1:0] addr;
		logic [tmrle_pkg::WORD_W-1:0] val;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tmrle_pkg::CFG_IDX_W-1:0] cfg_index = tmrle_pkg::REG_BASE_ADDRESS;
	logic [tmrle_pkg::ADDR_W-1:0]    cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [tmrle_pkg::WORD_W-1:0]    word = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [tmrle_pkg::ADDR_W-1:0]    tile_address;
	logic [tmrle_pkg::WORD_W-1:0]    tile_value;
	logic                            last;
	logic                            picture_done;
	logic                            overrun;

	// predictor state
	dec_phase_t                   dec_phase = EXPECT_TILE;
	logic [tmrle_pkg::WORD_W-1:0] held_value = '0;
	logic [tmrle_pkg::COL_W-1:0]  column = '0;
	logic [tmrle_pkg::ROW_W-1:0]  row = '0;
	logic [tmrle_pkg::ADDR_W-1:0] write_addr = tmrle_pkg::BASE_RESET;
	logic [tmrle_pkg::ADDR_W-1:0] base_reg = tmrle_pkg::BASE_RESET;
	logic                         fix_on = 1'b0;

	tile_wr_t tile_queue[$];
	int src_idle = 0;
	int sink_stall = 0;
	int errors = 0;
	int words_taken = 0;
	int writes_seen = 0;
	int pictures_seen = 0;
	int clipped_seen = 0;

	// reset base is 0x10F030; row n starts at base + n*0x80
	dir_row_t dir_rows [0:23] = '{
		'{16'h0001, 1'b1, 24'h10F030, 16'h0001},
		'{16'hFFFF, 1'b1, 24'h10F032, 16'hFFFF},
		'{16'h8000, 1'b1, 24'h10F034, 16'h8000},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'h0000, 1'b1, 24'h10F036, 16'h0000},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'h1234, 1'b0, 24'h0, 16'h0},
		'{16'h0001, 1'b0, 24'h0, 16'h0},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'hABCD, 1'b0, 24'h0, 16'h0},
		'{16'h0021, 1'b0, 24'h0, 16'h0},
		'{16'h00FF, 1'b1, 24'h10F0B0, 16'h00FF},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'h5555, 1'b0, 24'h0, 16'h0},
		'{16'h003E, 1'b0, 24'h0, 16'h0},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'hAAAA, 1'b0, 24'h0, 16'h0},
		'{16'hFFFF, 1'b0, 24'h0, 16'h0},
		'{16'h0000, 1'b0, 24'h0, 16'h0},
		'{16'h0007, 1'b0, 24'h0, 16'h0},
		'{16'h003F, 1'b0, 24'h0, 16'h0},
		'{16'h7FFF, 1'b1, 24'h10F230, 16'h7FFF},
		'{16'h0000, 1'b0, 24'h0, 16'h0}
	};

	tilemap_rle_word_decoder_unit #(
		.ROWS(ROWS), .COLUMNS(COLUMNS), .ROW_STRIDE(ROW_STRIDE), .MAX_RUN(MAX_RUN)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .word(word),
		.out_valid(out_valid), .out_stall(out_stall),
		.tile_address(tile_address), .tile_value(tile_value),
		.last(last), .picture_done(picture_done), .overrun(overrun)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < sink_stall);
	end

	// tile writes caused by one compressed word
	function automatic void decode_word(input logic [tmrle_pkg::WORD_W-1:0] w,
			output tile_wr_t batch[$]);
		logic [tmrle_pkg::WORD_W-1:0] v;
		int copies;
		logic done, over;
		batch.delete();
		done = 1'b0;
		over = 1'b0;
		v = w;
		copies = 1;
		case (dec_phase)
			EXPECT_VALUE: begin
				held_value = w;
				dec_phase = EXPECT_COUNT;
				return;
			end
			EXPECT_COUNT: begin
				v = held_value;
				copies = int'(w) + 1;
				if (copies > MAX_RUN) begin
					copies = MAX_RUN;
					over = 1'b1;
				end
			end
			default: begin
				if (w == '0) begin
					dec_phase = EXPECT_VALUE;
					return;
				end
			end
		endcase
		dec_phase = EXPECT_TILE;
		// a run is never split at the row end
		repeat (copies) begin
			batch.push_back('{addr: write_addr, val: v, last: 1'b0, done: 1'b0, over: 1'b0});
			write_addr += 24'd2;
			column += 7'd1;
		end
		if (column >= COLUMNS) begin
			column = '0;
			row += 5'd1;
			if (row >= ROWS) begin
				if (fix_on)
					batch.push_back('{addr: tmrle_pkg::FIX_ADDRESS,
						val: tmrle_pkg::FIX_VALUE, last: 1'b0, done: 1'b0, over: 1'b0});
				row = '0;
				write_addr = base_reg;
				done = 1'b1;
			end else begin
				write_addr = base_reg
					+ tmrle_pkg::ADDR_W'(row) * tmrle_pkg::ADDR_W'(ROW_STRIDE);
			end
		end
		batch[$].last = 1'b1;
		batch[$].done = done;
		batch[$].over = over;
	endfunction

	task automatic flag_mismatch(input string field, input logic [tmrle_pkg::ADDR_W-1:0] got,
			input logic [tmrle_pkg::ADDR_W-1:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH write %0d: %s got %h want %h", writes_seen, field, got, want);
	endtask

	// a beat seen at the falling edge is taken at the next rising edge
	always @(negedge clk) begin
		tile_wr_t want;
		if (arst_n && out_valid && !out_stall) begin
			writes_seen++;
			if (picture_done === 1'b1)
				pictures_seen++;
			if (overrun === 1'b1)
				clipped_seen++;
			if (tile_queue.size() == 0) begin
				flag_mismatch("unexpected write, address", tile_address, '0);
			end else begin
				want = tile_queue.pop_front();
				if (tile_address !== want.addr)
					flag_mismatch("tile_address", tile_address, want.addr);
				if (tile_value !== want.val)
					flag_mismatch("tile_value", tmrle_pkg::ADDR_W'(tile_value),
						tmrle_pkg::ADDR_W'(want.val));
				if (last !== want.last)
					flag_mismatch("last", tmrle_pkg::ADDR_W'(last),
						tmrle_pkg::ADDR_W'(want.last));
				if (picture_done !== want.done)
					flag_mismatch("picture_done", tmrle_pkg::ADDR_W'(picture_done),
						tmrle_pkg::ADDR_W'(want.done));
				if (overrun !== want.over)
					flag_mismatch("overrun", tmrle_pkg::ADDR_W'(overrun),
						tmrle_pkg::ADDR_W'(want.over));
			end
		end
	end

	task automatic send_word(input logic [tmrle_pkg::WORD_W-1:0] w, input logic typed,
			input tile_wr_t typed_wr);
		tile_wr_t batch[$];
		bit taken;
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		words_taken++;
		decode_word(w, batch);
		if (typed)
			tile_queue.push_back(typed_wr);
		else
			foreach (batch[i])
				tile_queue.push_back(batch[i]);
	endtask

	task automatic write_reg(input logic [tmrle_pkg::CFG_IDX_W-1:0] idx,
			input logic [tmrle_pkg::ADDR_W-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		if (idx == tmrle_pkg::REG_BASE_ADDRESS)
			base_reg = data;
		else if (idx == tmrle_pkg::REG_FIX_ENABLE)
			fix_on = data[0];
	endtask

	// escape and value words leave no trace, so the clock runs on past the last write
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (tile_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input logic [tmrle_pkg::ADDR_W-1:0] base, input logic fix,
			input int src_pct, input int sink_pct, input int n_words, input bit hold_off);
		int n;
		int r;
		int cnt;
		bit held;
		n = 0;
		held = 1'b0;
		write_reg(tmrle_pkg::REG_BASE_ADDRESS, base);
		write_reg(tmrle_pkg::REG_FIX_ENABLE, tmrle_pkg::ADDR_W'(fix));
		cfg_valid <= 1'b0;
		src_idle = src_pct;
		sink_stall = sink_pct;
		while (n < n_words) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					cnt = $urandom_range(39, 62);
				else if (r < 85)
					cnt = $urandom_range(0, 65535);
				else
					cnt = $urandom_range(0, 38);
				send_word('0, 1'b0, '0);
				send_word(tmrle_pkg::WORD_W'($urandom_range(0, 65535)), 1'b0, '0);
				send_word(tmrle_pkg::WORD_W'(cnt), 1'b0, '0);
				n += 3;
			end else if (r < 90) begin
				send_word(tmrle_pkg::WORD_W'($urandom_range(1, 65535)), 1'b0, '0);
				n++;
			end else begin
				// raw noise, a stray zero breaks into an escape
				send_word(tmrle_pkg::WORD_W'($urandom_range(0, 65535)), 1'b0, '0);
				n++;
			end
			if (hold_off && !held && n >= 20) begin
				held = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (tile_queue.size() != 0)
					@(posedge clk);
			end
		end
		drain_and_settle();
	endtask

	initial begin
		tile_wr_t tw;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			tw = '{addr: dir_rows[i].addr, val: dir_rows[i].val, last: 1'b1, done: 1'b0, over: 1'b0};
			send_word(dir_rows[i].w, dir_rows[i].typed, tw);
		end
		drain_and_settle();

		run_random(24'h000000, 1'b1, 0, 0, 50, 1'b0);
		run_random(24'hFFFFFF, 1'b0, 82, 0, 50, 1'b0);
		run_random(tmrle_pkg::ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b1, 0, 82, 55, 1'b0);
		run_random(tmrle_pkg::BASE_RESET, 1'b1, 22, 22, 55, 1'b1);

		$display("Run covered %0d words and %0d tile writes: %0d pictures done, %0d clipped runs,",
			words_taken, writes_seen, pictures_seen, clipped_seen);
		$display("bases at both ends and reset, fix write on and off, four idle/stall mixes.");
		if (errors == 0)
			$display("tb_tilemap_rle_word_decoder_unit passed");
		else
			$display("tb_tilemap_rle_word_decoder_unit failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_tilemap_rle_word_decoder_unit failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/tmrle_pkg.sv
rtl/tmrle_datapath.sv
rtl/tmrle_ctrl.sv
rtl/tilemap_rle_word_decoder_unit.sv
test/tb_tilemap_rle_word_decoder_unit.sv
